### rtl/core/lmm_pkg.sv
// ----------------------------------------------------------------------------
// lmm_pkg
// Shared types, sizes and helpers of the LED strip level meter mapper.
// ----------------------------------------------------------------------------
package lmm_pkg;

	localparam int STRIP_PIXELS = 16;              // pixels on the strip, 3..64
	localparam int LEVEL_W      = 16;
	localparam int MAX_W        = 8;
	localparam int PIX_W        = 6;
	localparam int FRAC_W       = 15;
	localparam int LEVEL_ONE    = 32768;           // 1.0 in Q1.15
	localparam int POS_W        = $clog2(LEVEL_ONE * STRIP_PIXELS + 1);
	localparam int FULL_W       = POS_W - FRAC_W;  // holds 0..STRIP_PIXELS
	localparam int CMP_W        = (FULL_W > PIX_W) ? FULL_W : PIX_W;
	localparam int PROD_W       = LEVEL_W + MAX_W;
	localparam int THIRD        = STRIP_PIXELS / 3;
	localparam int LAST_PIX     = STRIP_PIXELS - 1;

	localparam logic [MAX_W-1:0] MAX_RED_RST   = 8'd255;
	localparam logic [MAX_W-1:0] MAX_GREEN_RST = 8'd70;
	localparam logic [MAX_W-1:0] MAX_BLUE_RST  = 8'd70;

	typedef enum logic [2:0] {
		MODE_UNIFORM = 3'd0,
		MODE_SPLIT   = 3'd1,
		MODE_RED     = 3'd2,
		MODE_BAR_R   = 3'd3,
		MODE_BAR_G   = 3'd4,
		MODE_BAR_B   = 3'd5,
		MODE_BAR_ALL = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		REG_MODE      = 2'd0,
		REG_MAX_RED   = 2'd1,
		REG_MAX_GREEN = 2'd2,
		REG_MAX_BLUE  = 2'd3
	} reg_idx_t;

	// lane stage loads
	typedef struct packed {
		logic load_s2;
		logic load_s3;
	} lane_ctl_t;

	function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] lvl);
		clamp_level = (lvl > LEVEL_W'(LEVEL_ONE)) ? LEVEL_W'(LEVEL_ONE) : lvl;
	endfunction

endpackage

### rtl/core/lmm_lane.sv
// ----------------------------------------------------------------------------
// lmm_lane
// One color channel: scaled level, bar position and per-pixel bar value.
// ----------------------------------------------------------------------------
module lmm_lane import lmm_pkg::*; (
	input  logic               clk,
	input  lane_ctl_t          ctl,
	input  logic [LEVEL_W-1:0] level_s1,
	input  logic [MAX_W-1:0]   mx,
	input  logic [PIX_W-1:0]   pix,
	output logic [MAX_W-1:0]   scaled,
	output logic [MAX_W-1:0]   bar
);

	logic [MAX_W-1:0]  scaled_s2;
	logic [POS_W-1:0]  pos_s2;
	logic [MAX_W-1:0]  scaled_s3;
	logic [FULL_W-1:0] full_s3;
	logic [MAX_W-1:0]  partial_s3;
	logic              frac_nz_s3;

	logic [PROD_W-1:0] level_prod;
	logic [PROD_W-1:0] frac_prod;

	assign level_prod = PROD_W'(level_s1) * PROD_W'(mx);
	assign frac_prod  = PROD_W'(pos_s2[FRAC_W-1:0]) * PROD_W'(mx);

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			scaled_s2 <= level_prod[FRAC_W +: MAX_W];
			pos_s2    <= POS_W'(level_s1) * POS_W'(STRIP_PIXELS);
		end
		if (ctl.load_s3) begin
			scaled_s3  <= scaled_s2;
			full_s3    <= pos_s2[POS_W-1:FRAC_W];
			partial_s3 <= frac_prod[FRAC_W +: MAX_W];
			frac_nz_s3 <= |pos_s2[FRAC_W-1:0];
		end
	end

	always_comb begin
		if (CMP_W'(pix) < CMP_W'(full_s3))
			bar = mx;
		else if ((CMP_W'(pix) == CMP_W'(full_s3)) && frac_nz_s3)
			bar = partial_s3;
		else
			bar = '0;
	end

	assign scaled = scaled_s3;

endmodule

### rtl/core/lmm_merge.sv
// ----------------------------------------------------------------------------
// lmm_merge
// Picks each channel's value by display mode and registers the pixel word.
// ----------------------------------------------------------------------------
module lmm_merge import lmm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [PIX_W-1:0] pix,
	input  mode_t            mode,
	input  logic [MAX_W-1:0] sc_r,
	input  logic [MAX_W-1:0] sc_g,
	input  logic [MAX_W-1:0] sc_b,
	input  logic [MAX_W-1:0] bar_r,
	input  logic [MAX_W-1:0] bar_g,
	input  logic [MAX_W-1:0] bar_b,
	output logic             pixel_strobe,
	output logic [PIX_W-1:0] pixel_index,
	output logic [23:0]      grb_word,
	output logic             last_pixel
);

	logic [MAX_W-1:0] r, g, b;

	always_comb begin
		r = '0;
		g = '0;
		b = '0;
		case (mode)
			MODE_UNIFORM: begin
				r = sc_r;
				g = sc_g;
				b = sc_b;
			end
			MODE_SPLIT: begin
				if (pix < PIX_W'(THIRD))
					r = sc_r;
				else if (pix < PIX_W'(2 * THIRD))
					g = sc_g;
				else
					b = sc_b;
			end
			MODE_RED:   r = sc_r;
			MODE_BAR_R: r = bar_r;
			MODE_BAR_G: g = bar_g;
			MODE_BAR_B: b = bar_b;
			default: begin
				r = bar_r;
				g = bar_g;
				b = bar_b;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pixel_strobe <= 1'b0;
		else
			pixel_strobe <= fire;
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pixel_index <= pix;
			grb_word    <= {g, r, b};
			last_pixel  <= (pix == PIX_W'(LAST_PIX));
		end
	end

endmodule

### rtl/core/led_strip_level_meter_mapper.sv
// ----------------------------------------------------------------------------
// led_strip_level_meter_mapper
// Maps three Q1.15 channel levels to one GRB word per strip pixel.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                       Handshake
// -------   -------------------------------------------   ----------------------
// request   start, red_level, green_level, blue_level     taken when start & !busy
// pixel     pixel_strobe, pixel_index, grb_word,          one-cycle strobe per result,
//           last_pixel                                    no backpressure
// config    cfg_we, cfg_index, cfg_data                   written when cfg_we
//
// Rate: each request yields STRIP_PIXELS pixels, one per clock, paced by the
//   pixel counter of the frame stage.
// Path: a taken request passes stages 1, 2, 3 and the merge register before pixel 0 is strobed.
// Frames stream gap-free: the next request is prepared in stages 1-2 while the
//   current frame is emitted; busy is high while stage 1 holds a waiting request.
// Reset: mode uniform, maxima 255/70/70, pipeline empty, no strobe.
//
// Pipeline: s1 clamped levels, s2 scaled level and bar position (lane
// multiply), s3 partial pixel color (lane multiply) held for the frame,
// then the merge stage registers each pixel.
// ----------------------------------------------------------------------------
module led_strip_level_meter_mapper import lmm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [LEVEL_W-1:0] red_level,
	input  logic [LEVEL_W-1:0] green_level,
	input  logic [LEVEL_W-1:0] blue_level,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [MAX_W-1:0]   cfg_data,
	output logic               pixel_strobe,
	output logic [PIX_W-1:0]   pixel_index,
	output logic [23:0]        grb_word,
	output logic               last_pixel
);

	// config registers
	mode_t            mode_q;
	logic [MAX_W-1:0] max_r_q, max_g_q, max_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_UNIFORM;
			max_r_q <= MAX_RED_RST;
			max_g_q <= MAX_GREEN_RST;
			max_b_q <= MAX_BLUE_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_MODE:      mode_q  <= (&cfg_data[2:0]) ? MODE_BAR_ALL
				                                           : mode_t'(cfg_data[2:0]);
				REG_MAX_RED:   max_r_q <= cfg_data;
				REG_MAX_GREEN: max_g_q <= cfg_data;
				REG_MAX_BLUE:  max_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage handshake; s3 frees on the last pixel so frames abut
	logic             s1_valid_q, s2_valid_q, s3_valid_q;
	logic [PIX_W-1:0] pix_q;
	logic             s3_done, load_s3, load_s2, s1_free, accept;
	lane_ctl_t        lane_ctl;

	assign s3_done = s3_valid_q && (pix_q == PIX_W'(LAST_PIX));
	assign load_s3 = s2_valid_q && (!s3_valid_q || s3_done);
	assign load_s2 = s1_valid_q && (!s2_valid_q || load_s3);
	assign s1_free = !s1_valid_q || load_s2;
	assign busy    = !s1_free;
	assign accept  = start && s1_free;

	assign lane_ctl.load_s2 = load_s2;
	assign lane_ctl.load_s3 = load_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
			s3_valid_q <= 1'b0;
			pix_q      <= '0;
		end else begin
			if (accept)
				s1_valid_q <= 1'b1;
			else if (load_s2)
				s1_valid_q <= 1'b0;

			if (load_s2)
				s2_valid_q <= 1'b1;
			else if (load_s3)
				s2_valid_q <= 1'b0;

			if (load_s3)
				s3_valid_q <= 1'b1;
			else if (s3_done)
				s3_valid_q <= 1'b0;

			if (s3_valid_q)
				pix_q <= s3_done ? '0 : pix_q + PIX_W'(1);
		end
	end

	// stage 1: clamped levels
	logic [LEVEL_W-1:0] lvl_r_s1, lvl_g_s1, lvl_b_s1;

	always_ff @(posedge clk) begin
		if (accept) begin
			lvl_r_s1 <= clamp_level(red_level);
			lvl_g_s1 <= clamp_level(green_level);
			lvl_b_s1 <= clamp_level(blue_level);
		end
	end

	// channel lanes
	logic [MAX_W-1:0] sc_r, sc_g, sc_b, bar_r, bar_g, bar_b;

	lmm_lane u_lane_r (
		.clk      (clk),
		.ctl      (lane_ctl),
		.level_s1 (lvl_r_s1),
		.mx       (max_r_q),
		.pix      (pix_q),
		.scaled   (sc_r),
		.bar      (bar_r)
	);

	lmm_lane u_lane_g (
		.clk      (clk),
		.ctl      (lane_ctl),
		.level_s1 (lvl_g_s1),
		.mx       (max_g_q),
		.pix      (pix_q),
		.scaled   (sc_g),
		.bar      (bar_g)
	);

	lmm_lane u_lane_b (
		.clk      (clk),
		.ctl      (lane_ctl),
		.level_s1 (lvl_b_s1),
		.mx       (max_b_q),
		.pix      (pix_q),
		.scaled   (sc_b),
		.bar      (bar_b)
	);

	// merge and output register
	lmm_merge u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (s3_valid_q),
		.pix          (pix_q),
		.mode         (mode_q),
		.sc_r         (sc_r),
		.sc_g         (sc_g),
		.sc_b         (sc_b),
		.bar_r        (bar_r),
		.bar_g        (bar_g),
		.bar_b        (bar_b),
		.pixel_strobe (pixel_strobe),
		.pixel_index  (pixel_index),
		.grb_word     (grb_word),
		.last_pixel   (last_pixel)
	);

`ifndef SYNTH
	a_frame_runs: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_strobe && !last_pixel |=>
			pixel_strobe && (pixel_index == $past(pixel_index) + PIX_W'(1)))
		else $error("frame broke before its last pixel");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_strobe && last_pixel |=> !pixel_strobe || (pixel_index == '0))
		else $error("frame did not restart at pixel zero");

	a_accept_held: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_valid_q)
		else $error("accepted request lost in stage 1");

	a_pix_range: assert property (@(posedge clk) disable iff (!arst_n)
		s3_valid_q |-> (pix_q <= PIX_W'(LAST_PIX)))
		else $error("pixel counter ran past the strip");
`endif

endmodule
